// ===== sv/assert_macros.svh =====
// -----------------------------------------------------------------------------
// Assertion macros
// Shared property forms; clk and rst_n are taken from the using scope.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define TCW_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define TCW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/tcw_pkg.sv =====
// -----------------------------------------------------------------------------
// tcw_pkg
// Character codes, command classes and queue beat layouts of the console.
// -----------------------------------------------------------------------------
package tcw_pkg;

    localparam int unsigned CHAR_W = 8;
    localparam int unsigned ADDR_W = 11;
    localparam int unsigned DATA_W = 16;

    localparam logic [CHAR_W-1:0] CH_BLANK = 8'h20;
    localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;

    localparam logic [1:0] FUNC_PUT   = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    typedef enum logic [2:0] {
        CMD_NOP,
        CMD_PUT,
        CMD_BS,
        CMD_TAB,
        CMD_CR,
        CMD_LF,
        CMD_READ,
        CMD_CLEAR
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t           kind;
        logic [CHAR_W-1:0]   ch;
        logic [ADDR_W-1:0]   addr;
        logic                read_ok;
    } cmd_t;

    typedef struct packed {
        logic [ADDR_W-1:0]   cursor_pos;
        logic [DATA_W-1:0]   cell_data;
    } res_t;

endpackage

// ===== sv/tcw_fifo.sv =====
// -----------------------------------------------------------------------------
// tcw_fifo
// Small register queue used for the command and result beats.
// -----------------------------------------------------------------------------
module tcw_fifo #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             wr_en;
    logic             rd_en;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign wr_en   = push && !full;
    assign rd_en   = pop && !empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== sv/tcw_front.sv =====
// -----------------------------------------------------------------------------
// tcw_front
// Classifies an incoming item into a command for the execution side.
// -----------------------------------------------------------------------------
module tcw_front import tcw_pkg::*; #(
    parameter int unsigned COLS = 80,
    parameter int unsigned ROWS = 25
) (
    input  logic [1:0]        func,
    input  logic [CHAR_W-1:0] char_byte,
    input  logic [ADDR_W-1:0] cell_addr,
    output cmd_t              cmd
);

    localparam int unsigned NCELLS = COLS * ROWS;

    always_comb
    begin
        cmd.ch      = char_byte;
        cmd.addr    = cell_addr;
        cmd.read_ok = (32'(cell_addr) < NCELLS);
        case (func)
            FUNC_PUT:
            begin
                case (char_byte)
                    CH_BS:   cmd.kind = CMD_BS;
                    CH_TAB:  cmd.kind = CMD_TAB;
                    CH_CR:   cmd.kind = CMD_CR;
                    CH_LF:   cmd.kind = CMD_LF;
                    default: cmd.kind = CMD_PUT;
                endcase
            end
            FUNC_READ:  cmd.kind = CMD_READ;
            FUNC_CLEAR: cmd.kind = CMD_CLEAR;
            default:    cmd.kind = CMD_NOP;
        endcase
    end

endmodule

// ===== sv/tcw_back.sv =====
// -----------------------------------------------------------------------------
// tcw_back
// Executes commands: cursor tracking, cell store, scroll and clear sweeps.
// -----------------------------------------------------------------------------
module tcw_back import tcw_pkg::*; #(
    parameter int unsigned COLS     = 80,
    parameter int unsigned ROWS     = 25,
    parameter int unsigned TAB_STEP = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CHAR_W-1:0] cell_attribute,
    input  logic              cmd_empty,
    input  cmd_t              cmd,
    output logic              cmd_pop,
    input  logic              res_full,
    output logic              res_push,
    output res_t              res
);

    localparam int unsigned NCELLS = COLS * ROWS;
    localparam int unsigned PW     = $clog2(NCELLS);
    localparam int unsigned RW     = $clog2(ROWS);
    localparam int unsigned CW     = $clog2(COLS);
    localparam int unsigned PH_W   = (TAB_STEP > 1) ? $clog2(TAB_STEP) : 1;
    localparam int unsigned COL_PH  = COLS % TAB_STEP;
    localparam int unsigned LAST_PH = (NCELLS - COLS) % TAB_STEP;

    localparam logic [PW-1:0] LAST_ROW_BASE = PW'(NCELLS - COLS);
    localparam logic [PW-1:0] LAST_CELL     = PW'(NCELLS - 1);
    localparam logic [PW-1:0] COPY_LAST     = PW'(NCELLS - COLS - 1);
    localparam logic [PW-1:0] ROW_STRIDE    = PW'(COLS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TAB,
        ST_READ,
        ST_SCROLL,
        ST_BLANK,
        ST_CLEAR
    } state_t;

    state_t            state_reg, state_next;
    logic [PW-1:0]     pos_reg, pos_next;
    logic [RW-1:0]     row_reg, row_next;
    logic [CW-1:0]     col_reg, col_next;
    logic [PH_W-1:0]   ph_reg, ph_next;
    logic [PH_W-1:0]   rowph_reg, rowph_next;
    logic [PW-1:0]     cnt_reg, cnt_next;
    logic              copy_pend_reg, copy_pend_next;
    logic [PW-1:0]     copy_dst_reg, copy_dst_next;
    logic [CHAR_W-1:0] attr_reg;
    logic [DATA_W-1:0] rd_data_reg;

    logic [DATA_W-1:0] cells_mem [NCELLS];

    logic              mem_we;
    logic [PW-1:0]     mem_waddr;
    logic [DATA_W-1:0] mem_wdata;
    logic              mem_re;
    logic [PW-1:0]     mem_raddr;

    logic              at_last_col;
    logic              at_last_row;
    logic              inc_wrap;
    logic              do_inc;
    logic              do_scroll;
    logic              done;
    logic [DATA_W-1:0] done_data;
    logic [DATA_W-1:0] blank;
    logic [15:0]       addr16;
    logic [15:0]       pos16;

    function automatic logic [PH_W-1:0] ph_inc(input logic [PH_W-1:0] p);
        return (p == PH_W'(TAB_STEP - 1)) ? '0 : PH_W'(p + 1'b1);
    endfunction

    function automatic logic [PH_W-1:0] ph_dec(input logic [PH_W-1:0] p);
        return (p == '0) ? PH_W'(TAB_STEP - 1) : PH_W'(p - 1'b1);
    endfunction

    function automatic logic [PH_W-1:0] rowph_add(input logic [PH_W-1:0] p);
        logic [PH_W:0] s;
        s = {1'b0, p} + (PH_W+1)'(COL_PH);
        return (s >= (PH_W+1)'(TAB_STEP)) ? PH_W'(s - (PH_W+1)'(TAB_STEP)) : s[PH_W-1:0];
    endfunction

    function automatic logic [PH_W-1:0] rowph_sub(input logic [PH_W-1:0] p);
        logic [PH_W:0] s;
        s = {1'b0, p} + (PH_W+1)'(TAB_STEP - COL_PH);
        return (p >= PH_W'(COL_PH)) ? PH_W'(p - PH_W'(COL_PH)) : s[PH_W-1:0];
    endfunction

    assign cfg_ready   = 1'b1;
    assign blank       = {attr_reg, CH_BLANK};
    assign at_last_col = (col_reg == CW'(COLS - 1));
    assign at_last_row = (row_reg == RW'(ROWS - 1));
    assign inc_wrap    = at_last_col && at_last_row;
    assign addr16      = 16'(cmd.addr);

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        ph_next        = ph_reg;
        rowph_next     = rowph_reg;
        cnt_next       = cnt_reg;
        copy_pend_next = 1'b0;
        copy_dst_next  = copy_dst_reg;
        cmd_pop        = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = '0;
        mem_wdata      = '0;
        mem_re         = 1'b0;
        mem_raddr      = '0;
        do_inc         = 1'b0;
        do_scroll      = 1'b0;
        done           = 1'b0;
        done_data      = '0;

        // land the copy read issued in the previous scroll cycle
        if (copy_pend_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = copy_dst_reg;
            mem_wdata = rd_data_reg;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (!cmd_empty && !res_full)
                begin
                    cmd_pop = 1'b1;
                    case (cmd.kind)
                        CMD_PUT:
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = pos_reg;
                            mem_wdata = {attr_reg, cmd.ch};
                            do_inc    = 1'b1;
                            done      = !inc_wrap;
                        end
                        CMD_BS:
                        begin
                            done = 1'b1;
                            if (pos_reg != '0)
                            begin
                                pos_next = pos_reg - 1'b1;
                                ph_next  = ph_dec(ph_reg);
                                if (col_reg == '0)
                                begin
                                    row_next   = row_reg - 1'b1;
                                    col_next   = CW'(COLS - 1);
                                    rowph_next = rowph_sub(rowph_reg);
                                end
                                else
                                begin
                                    col_next = col_reg - 1'b1;
                                end
                            end
                        end
                        CMD_TAB:
                        begin
                            do_inc     = 1'b1;
                            done       = !inc_wrap && (ph_inc(ph_reg) == '0);
                            state_next = done ? ST_IDLE : ST_TAB;
                        end
                        CMD_CR:
                        begin
                            pos_next = pos_reg - PW'(col_reg);
                            col_next = '0;
                            ph_next  = rowph_reg;
                            done     = 1'b1;
                        end
                        CMD_LF:
                        begin
                            if (at_last_row)
                            begin
                                do_scroll = 1'b1;
                            end
                            else
                            begin
                                pos_next   = pos_reg - PW'(col_reg) + ROW_STRIDE;
                                row_next   = row_reg + 1'b1;
                                col_next   = '0;
                                rowph_next = rowph_add(rowph_reg);
                                ph_next    = rowph_add(rowph_reg);
                                done       = 1'b1;
                            end
                        end
                        CMD_READ:
                        begin
                            if (cmd.read_ok)
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = addr16[PW-1:0];
                                state_next = ST_READ;
                            end
                            else
                            begin
                                done = 1'b1;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            pos_next   = '0;
                            row_next   = '0;
                            col_next   = '0;
                            ph_next    = '0;
                            rowph_next = '0;
                            cnt_next   = '0;
                            state_next = ST_CLEAR;
                        end
                        default:
                        begin
                            done = 1'b1;
                        end
                    endcase
                end
            end
            ST_TAB:
            begin
                do_inc     = 1'b1;
                done       = !inc_wrap && (ph_inc(ph_reg) == '0);
                state_next = done ? ST_IDLE : ST_TAB;
            end
            ST_READ:
            begin
                done       = 1'b1;
                done_data  = rd_data_reg;
                state_next = ST_IDLE;
            end
            ST_SCROLL:
            begin
                // read one row ahead, write back next cycle
                mem_re         = 1'b1;
                mem_raddr      = cnt_reg + ROW_STRIDE;
                copy_pend_next = 1'b1;
                copy_dst_next  = cnt_reg;
                if (cnt_reg == COPY_LAST)
                begin
                    cnt_next   = LAST_ROW_BASE;
                    state_next = ST_BLANK;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_BLANK:
            begin
                if (!copy_pend_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = cnt_reg;
                    mem_wdata = blank;
                    if (cnt_reg == LAST_CELL)
                    begin
                        done       = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = cnt_reg;
                mem_wdata = blank;
                if (cnt_reg == LAST_CELL)
                begin
                    done       = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (do_inc)
        begin
            if (inc_wrap)
            begin
                do_scroll = 1'b1;
            end
            else
            begin
                pos_next = pos_reg + 1'b1;
                ph_next  = ph_inc(ph_reg);
                if (at_last_col)
                begin
                    row_next   = row_reg + 1'b1;
                    col_next   = '0;
                    rowph_next = ph_inc(ph_reg);
                end
                else
                begin
                    col_next = col_reg + 1'b1;
                end
            end
        end

        if (do_scroll)
        begin
            pos_next   = LAST_ROW_BASE;
            row_next   = RW'(ROWS - 1);
            col_next   = '0;
            ph_next    = PH_W'(LAST_PH);
            rowph_next = PH_W'(LAST_PH);
            cnt_next   = '0;
            state_next = ST_SCROLL;
        end
    end

    assign pos16          = 16'(pos_next);
    assign res_push       = done;
    assign res.cursor_pos = pos16[ADDR_W-1:0];
    assign res.cell_data  = done_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            ph_reg        <= '0;
            rowph_reg     <= '0;
            cnt_reg       <= '0;
            copy_pend_reg <= 1'b0;
            copy_dst_reg  <= '0;
            attr_reg      <= 8'd15;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            ph_reg        <= ph_next;
            rowph_reg     <= rowph_next;
            cnt_reg       <= cnt_next;
            copy_pend_reg <= copy_pend_next;
            copy_dst_reg  <= copy_dst_next;
            if (cfg_valid)
            begin
                attr_reg <= cell_attribute;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            cells_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= cells_mem[mem_raddr];
        end
    end

endmodule

// ===== sv/text_console_writer_top.sv =====
// -----------------------------------------------------------------------------
// text_console_writer_top: text-mode console with cursor and cell store
// Put, BS, CR and LF go 1 item per cycle while the result queue has room and no
// scroll starts; read, tab, scroll and clear hold off the next item until done.
// Reset: cursor 0, attribute 15; cell store not cleared, no clearing pass.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module text_console_writer_top import tcw_pkg::*; #(
    parameter int unsigned COLS     = 80,
    parameter int unsigned ROWS     = 25,
    parameter int unsigned TAB_STEP = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [1:0]        func,
    input  logic [CHAR_W-1:0] char_byte,
    input  logic [ADDR_W-1:0] cell_addr,
    output logic              empty,
    input  logic              pop,
    output logic [ADDR_W-1:0] cursor_pos,
    output logic [DATA_W-1:0] cell_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CHAR_W-1:0] cell_attribute
);

    localparam int unsigned NCELLS = COLS * ROWS;

    cmd_t cmd_in;
    cmd_t cmd_out;
    logic cmd_empty;
    logic cmd_pop;
    res_t res_in;
    res_t res_out;
    logic res_full;
    logic res_push;

    tcw_front #(
        .COLS (COLS),
        .ROWS (ROWS)
    ) u_front (
        .func      (func),
        .char_byte (char_byte),
        .cell_addr (cell_addr),
        .cmd       (cmd_in)
    );

    tcw_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (2)
    ) u_cmd_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (cmd_in),
        .full    (full),
        .pop     (cmd_pop),
        .rd_data (cmd_out),
        .empty   (cmd_empty)
    );

    tcw_back #(
        .COLS     (COLS),
        .ROWS     (ROWS),
        .TAB_STEP (TAB_STEP)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cell_attribute (cell_attribute),
        .cmd_empty      (cmd_empty),
        .cmd            (cmd_out),
        .cmd_pop        (cmd_pop),
        .res_full       (res_full),
        .res_push       (res_push),
        .res            (res_in)
    );

    tcw_fifo #(
        .WIDTH ($bits(res_t)),
        .DEPTH (2)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (res_push),
        .wr_data (res_in),
        .full    (res_full),
        .pop     (pop),
        .rd_data (res_out),
        .empty   (empty)
    );

    assign cursor_pos = res_out.cursor_pos;
    assign cell_data  = res_out.cell_data;

    `TCW_ASSERT_IMPLY(a_pop_with_room, cmd_pop, !cmd_empty && !res_full, "pop without result room")
    `TCW_ASSERT_IMPLY(a_no_res_overflow, res_push, !res_full, "result beat pushed into full queue")
    `TCW_ASSERT_IMPLY(a_cursor_in_range, !empty, 32'(cursor_pos) < NCELLS, "cursor beyond screen")
    `TCW_ASSERT_NEXT(a_res_held, res_full && !pop, !empty, "result queue lost a beat")

endmodule

// ===== tb/text_console_writer_top_tb.sv =====
// -----------------------------------------------------------------------------
// text_console_writer_top_tb
// Drives put, read, clear and unused commands into the console through its
// queue ports and checks every result against a shadow copy of the cell store
// and cursor. The run covers several attribute settings, with random stalls
// on both sides and a stall-free tail.
// -----------------------------------------------------------------------------
module text_console_writer_top_tb import tcw_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned COLS     = 80;
    localparam int unsigned ROWS     = 25;
    localparam int unsigned TAB_STEP = 4;
    localparam int unsigned NCELLS   = COLS * ROWS;
    localparam int unsigned ADDR_MAX = (1 << ADDR_W) - 1;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    localparam int unsigned PHASE_ITEMS = 150;
    localparam int unsigned NUM_PHASES  = 6;
    // a scroll or clear walks the whole store
    localparam int unsigned DRAIN_CYCLES = NCELLS + 8;
    // every item a scroll, each with the longest gap and stall, several times over
    localparam int unsigned CYCLE_LIMIT  = 8000000;

    typedef enum {
        RUN_TEXT,
        RUN_NEWLINES,
        RUN_CONTROL,
        RUN_READS,
        RUN_CLEAR,
        RUN_UNUSED
    } run_kind_t;

    // Shadow of the cell store and cursor, plus the results it predicts
    class console_shadow;
        logic [DATA_W-1:0] cells [NCELLS];
        bit                cell_known [NCELLS];
        int unsigned       cursor;
        logic [7:0]        attr;
        res_t              pending_results [$];
        int                errors;

        function new();
            cursor = 0;
            attr   = 8'd15;
            errors = 0;
            foreach (cell_known[i]) cell_known[i] = 1'b0;
        endfunction

        function void set_attribute(logic [7:0] value);
            attr = value;
        endfunction

        function void scroll_up();
            for (int unsigned i = 0; i + COLS < NCELLS; i++) begin
                cells[i]      = cells[i + COLS];
                cell_known[i] = cell_known[i + COLS];
            end
            for (int unsigned i = NCELLS - COLS; i < NCELLS; i++) begin
                cells[i]      = {attr, CH_BLANK};
                cell_known[i] = 1'b1;
            end
        endfunction

        function void accept_command(logic [1:0] op, logic [CHAR_W-1:0] ch,
                                     logic [ADDR_W-1:0] addr);
            int unsigned next_pos;
            res_t        want;
            next_pos       = cursor;
            want.cell_data = '0;
            case (op)
                FUNC_PUT:
                begin
                    if (ch == CH_BS)
                    begin
                        if (next_pos != 0) next_pos--;
                    end
                    else if (ch == CH_TAB)
                        next_pos = (next_pos + TAB_STEP) / TAB_STEP * TAB_STEP;
                    else if (ch == CH_CR)
                        next_pos = next_pos / COLS * COLS;
                    else if (ch == CH_LF)
                        next_pos = (next_pos / COLS + 1) * COLS;
                    else
                    begin
                        cells[next_pos]      = {attr, ch};
                        cell_known[next_pos] = 1'b1;
                        next_pos++;
                    end
                    if (next_pos >= NCELLS)
                    begin
                        scroll_up();
                        next_pos = NCELLS - COLS;
                    end
                end
                FUNC_READ:
                begin
                    if (addr < NCELLS) want.cell_data = cells[addr];
                end
                FUNC_CLEAR:
                begin
                    foreach (cells[i])
                    begin
                        cells[i]      = {attr, CH_BLANK};
                        cell_known[i] = 1'b1;
                    end
                    next_pos = 0;
                end
                default: ;
            endcase
            cursor          = next_pos;
            want.cursor_pos = cursor[ADDR_W-1:0];
            pending_results.push_back(want);
        endfunction

        function void check_result(logic [ADDR_W-1:0] pos, logic [DATA_W-1:0] data);
            res_t want;
            if (pending_results.size() == 0)
            begin
                $error("unexpected result beat: cursor_pos %0d cell_data 0x%04h", pos, data);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (pos !== want.cursor_pos)
            begin
                $error("cursor_pos: expected %0d actual %0d", want.cursor_pos, pos);
                errors++;
            end
            if (data !== want.cell_data)
            begin
                $error("cell_data: expected 0x%04h actual 0x%04h", want.cell_data, data);
                errors++;
            end
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        // Read target: a written cell, sometimes the one behind the cursor, or past the store
        function logic [ADDR_W-1:0] pick_read_addr();
            int unsigned a;
            if ($urandom_range(0, 9) == 0) return ADDR_W'($urandom_range(NCELLS, ADDR_MAX));
            if ($urandom_range(0, 2) == 0 && cursor != 0 && cell_known[cursor - 1])
                return ADDR_W'(cursor - 1);
            repeat (16)
            begin
                a = $urandom_range(0, NCELLS - 1);
                if (cell_known[a]) return ADDR_W'(a);
            end
            for (a = 0; a < NCELLS; a++)
                if (cell_known[a]) return ADDR_W'(a);
            return ADDR_W'($urandom_range(NCELLS, ADDR_MAX));
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              push = 1'b0;
    logic              full;
    logic [1:0]        func = FUNC_PUT;
    logic [CHAR_W-1:0] char_byte = '0;
    logic [ADDR_W-1:0] cell_addr = '0;
    logic              empty;
    logic              pop = 1'b0;
    logic [ADDR_W-1:0] cursor_pos;
    logic [DATA_W-1:0] cell_data;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [CHAR_W-1:0] cell_attribute = '0;

    console_shadow shadow = new();
    bit            idling_on = 1'b1;
    int unsigned   pop_stall_left = 0;
    int unsigned   cycle_count = 0;

    text_console_writer_top #(
        .COLS     (COLS),
        .ROWS     (ROWS),
        .TAB_STEP (TAB_STEP)
    ) uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .func           (func),
        .char_byte      (char_byte),
        .cell_addr      (cell_addr),
        .empty          (empty),
        .pop            (pop),
        .cursor_pos     (cursor_pos),
        .cell_data      (cell_data),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cell_attribute (cell_attribute)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Result side: pop, with random stall bursts
    always @(posedge clk)
    begin
        if (pop_stall_left != 0)
        begin
            pop            <= 1'b0;
            pop_stall_left <= pop_stall_left - 1;
        end
        else if (idling_on && $urandom_range(0, 9) == 0)
        begin
            pop            <= 1'b0;
            pop_stall_left <= $urandom_range(0, 6);
        end
        else
            pop <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
            shadow.check_result(cursor_pos, cell_data);
    end

    task automatic send_item(input logic [1:0] op, input logic [CHAR_W-1:0] ch,
                             input logic [ADDR_W-1:0] addr);
        push      <= 1'b1;
        func      <= op;
        char_byte <= ch;
        cell_addr <= addr;
        @(posedge clk);
        while (full) @(posedge clk);
        shadow.accept_command(op, ch, addr);
    endtask

    task automatic hold_push(input int unsigned cycles);
        push <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic maybe_gap();
        if (idling_on && $urandom_range(0, 4) == 0)
            hold_push($urandom_range(1, 7));
    endtask

    task automatic send_put(input logic [CHAR_W-1:0] ch);
        maybe_gap();
        send_item(FUNC_PUT, ch, ADDR_W'($urandom_range(0, ADDR_MAX)));
    endtask

    // Let the store settle once every beat is back, before touching the attribute
    task automatic drain();
        push <= 1'b0;
        while (shadow.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_attribute(input logic [7:0] value);
        cfg_valid      <= 1'b1;
        cell_attribute <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        shadow.set_attribute(value);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_directed();
        send_item(FUNC_UNUSED, 8'hFF, ADDR_W'(ADDR_MAX));
        send_item(FUNC_PUT, CH_BS, '0);                   // backspace at home
        send_item(FUNC_PUT, 8'h00, '0);
        send_item(FUNC_PUT, 8'hFF, ADDR_W'(ADDR_MAX));
        send_item(FUNC_READ, 8'h00, ADDR_W'(0));
        send_item(FUNC_READ, 8'hFF, ADDR_W'(1));
        send_item(FUNC_READ, 8'h00, ADDR_W'(ADDR_MAX));   // past the store
        send_item(FUNC_READ, 8'h00, ADDR_W'(NCELLS));
        send_item(FUNC_PUT, CH_TAB, '0);
        send_item(FUNC_PUT, 8'h41, '0);
        send_item(FUNC_PUT, CH_CR, '0);
        send_item(FUNC_PUT, CH_LF, '0);
        send_item(FUNC_PUT, CH_BS, '0);
        send_item(FUNC_READ, 8'h00, ADDR_W'(4));
        send_item(FUNC_CLEAR, 8'h00, '0);
        send_item(FUNC_READ, 8'h00, ADDR_W'(NCELLS - 1));
        send_item(FUNC_UNUSED, 8'h00, '0);
        send_item(FUNC_PUT, 8'h7E, ADDR_W'(0));
    endtask

    task automatic run_random(input int unsigned count);
        int unsigned sent;
        int unsigned len;
        run_kind_t   kind;
        int unsigned pick;
        logic [CHAR_W-1:0] ch;
        sent = 0;
        while (sent < count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)      kind = RUN_TEXT;
            else if (pick < 55) kind = RUN_NEWLINES;
            else if (pick < 70) kind = RUN_CONTROL;
            else if (pick < 90) kind = RUN_READS;
            else if (pick < 93) kind = RUN_CLEAR;
            else                kind = RUN_UNUSED;
            case (kind)
                RUN_TEXT:     len = $urandom_range(1, 40);
                RUN_NEWLINES: len = $urandom_range(1, 8);
                RUN_CONTROL:  len = $urandom_range(1, 8);
                RUN_READS:    len = $urandom_range(1, 6);
                RUN_CLEAR:    len = 1;
                default:      len = $urandom_range(1, 2);
            endcase
            repeat (len)
            begin
                case (kind)
                    RUN_TEXT:
                        send_put(CHAR_W'($urandom_range(0, 255)));
                    RUN_NEWLINES:
                        send_put(($urandom_range(0, 4) == 0) ? CH_CR : CH_LF);
                    RUN_CONTROL:
                    begin
                        case ($urandom_range(0, 3))
                            0:       ch = CH_BS;
                            1:       ch = CH_TAB;
                            2:       ch = CH_CR;
                            default: ch = CH_LF;
                        endcase
                        send_put(ch);
                    end
                    RUN_READS:
                    begin
                        maybe_gap();
                        send_item(FUNC_READ, CHAR_W'($urandom_range(0, 255)),
                                  shadow.pick_read_addr());
                    end
                    RUN_CLEAR:
                    begin
                        maybe_gap();
                        send_item(FUNC_CLEAR, CHAR_W'($urandom_range(0, 255)),
                                  ADDR_W'($urandom_range(0, ADDR_MAX)));
                    end
                    default:
                    begin
                        maybe_gap();
                        send_item(FUNC_UNUSED, CHAR_W'($urandom_range(0, 255)),
                                  ADDR_W'($urandom_range(0, ADDR_MAX)));
                    end
                endcase
                sent++;
            end
        end
    endtask

    initial
    begin
        logic [7:0] phase_attr [NUM_PHASES];
        phase_attr[0] = 8'hFF;
        phase_attr[1] = 8'h00;
        phase_attr[2] = 8'($urandom_range(0, 255));
        phase_attr[3] = 8'hA5;
        phase_attr[4] = 8'($urandom_range(0, 255));
        phase_attr[5] = 8'hFF;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            drain();
            write_attribute(phase_attr[p]);
            if (p == NUM_PHASES - 1) idling_on = 1'b0;
            run_random(PHASE_ITEMS);
        end

        drain();
        if (shadow.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/tcw_pkg.sv
sv/tcw_fifo.sv
sv/tcw_front.sv
sv/tcw_back.sv
sv/text_console_writer_top.sv
tb/text_console_writer_top_tb.sv
